[src/grid_local_minimum_risk_sum_core_defines.svh]
// Assertion macros for the grid local minimum core.
// Used by the top level only; relies on clk_i and rst_ni in the including scope.
`ifndef GRID_LOCAL_MINIMUM_RISK_SUM_CORE_DEFINES_SVH
`define GRID_LOCAL_MINIMUM_RISK_SUM_CORE_DEFINES_SVH

// Condition that holds at every clock edge out of reset.
`define GLMR_CHECK_NOW(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Same-cycle implication.
`define GLMR_CHECK_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GLMR_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/glmr_pkg.sv]
// Shared constants and types of the grid local minimum core.
// No dependencies; imported by the line cell, the line and the top level.
package glmr_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_WIDTH_W = 9;
  localparam int HEIGHT_W    = 4;
  localparam int RISK_W      = 32;
  localparam int COUNT_W     = 24;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = ROW_WIDTH_W'(100);
  localparam logic [COL_W-1:0]       RING_WM1_RESET  = COL_W'(100 - 1);

  typedef logic [COL_W-1:0] col_t;

  // One column of the two line stores.
  typedef struct packed {
    logic [HEIGHT_W-1:0] up2;  // row before the previous one
    logic [HEIGHT_W-1:0] up;   // previous row
  } cell_t;

  // Control broadcast along the line.
  typedef struct packed {
    logic  step;    // rotate the ring by one column
    logic  wr;      // overwrite the cell at wr_idx before it moves on
    col_t  wr_idx;
    col_t  wm1;     // ring width minus one
    cell_t wdata;
  } line_ctl_t;

endpackage

[src/grid_local_minimum_risk_sum_core.sv]
// Four-neighbor local minimum detector over a raster height map stream.
// One cell per cycle unless stalled; each result is registered and shows the cycle after transfer.
// Rate is set by the column ring: it advances one cell per transfer, in step with the stream.
// A change of the effective row width realigns the ring first, with the input stalled meanwhile.
// Reset clears control, totals and column state; line store contents stay undefined until written.
module grid_local_minimum_risk_sum_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [glmr_pkg::ROW_WIDTH_W-1:0]   cfg_row_width_i,
  // input cells
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [glmr_pkg::HEIGHT_W-1:0]      height_i,
  input  logic                               last_row_i,
  // results
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [glmr_pkg::RISK_W-1:0]        risk_sum_o,
  output logic [glmr_pkg::COUNT_W-1:0]       minima_count_o,
  output logic                               frame_done_o
);
  import glmr_pkg::*;

  `include "grid_local_minimum_risk_sum_core_defines.svh"

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  logic [ROW_WIDTH_W-1:0] row_width_q;
  col_t                   ring_wm1_q, ring_wm1_d;  // width minus one the ring is laid out for
  col_t                   ph_q, ph_d;              // column held in cell 0
  col_t                   col_q;                   // raw column of the next cell
  logic [1:0]             rows_q;                  // rows seen, saturates at two
  logic [HEIGHT_W-1:0]    r0_q, r1_q;              // last two cells received
  logic [RISK_W-1:0]      risk_q;
  logic [COUNT_W-1:0]     cnt_q;

  logic                   out_valid_q;
  logic [RISK_W-1:0]      out_risk_q;
  logic [COUNT_W-1:0]     out_cnt_q;
  logic                   out_done_q;

  // ---------------------------------------------------------------------
  // Effective width and column clamp
  // ---------------------------------------------------------------------
  col_t eff_wm1;
  col_t c_cur;
  col_t target_ph;
  col_t ph_inc;
  logic width_ok, aligned, realign_step, in_xfer;
  logic row_end, frame_end;

  // Width zero acts as one, anything beyond the store acts as the full store.
  always_comb begin
    if (row_width_q == '0) begin
      eff_wm1 = '0;
    end else if (row_width_q > ROW_WIDTH_W'(MAX_WIDTH)) begin
      eff_wm1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      eff_wm1 = COL_W'(row_width_q - 1'b1);
    end
  end

  // A column at or past the width counts as the last column.
  assign c_cur     = (col_q > eff_wm1) ? eff_wm1 : col_q;
  assign row_end   = (c_cur == eff_wm1);
  assign frame_end = last_row_i && row_end;

  // Cell 0 holds the column just left of the arriving one (wrapping).
  assign target_ph = (c_cur == '0) ? eff_wm1 : COL_W'(c_cur - 1'b1);
  assign ph_inc    = (ph_q == ring_wm1_q) ? '0 : COL_W'(ph_q + 1'b1);

  // Realign: unwind the old ring to phase zero, take the new width, then
  // rotate forward to the phase of the current column.
  assign width_ok     = (ring_wm1_q == eff_wm1);
  assign aligned      = width_ok && (ph_q == target_ph);
  assign realign_step = width_ok ? !aligned : (ph_q != '0);

  assign in_ready_o  = aligned && (!out_valid_q || out_ready_i);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign ring_wm1_d = (!width_ok && (ph_q == '0)) ? eff_wm1 : ring_wm1_q;
  assign ph_d       = (realign_step || in_xfer) ? ph_inc : ph_q;

  // ---------------------------------------------------------------------
  // Line store ring
  // ---------------------------------------------------------------------
  cell_t     cell0, cell1, cell2;
  cell_t     cur_cell;
  line_ctl_t line_ctl;
  logic [HEIGHT_W-1:0] above, above2, left_up2, right_up;

  // With a one-column ring the current column sits in cell 0; with two
  // columns the right neighbor wraps round to cell 0.
  assign cur_cell = (ring_wm1_q == '0) ? cell0 : cell1;
  assign above    = cur_cell.up;
  assign above2   = cur_cell.up2;
  assign left_up2 = cell0.up2;
  assign right_up = (ring_wm1_q == COL_W'(1)) ? cell0.up : cell2.up;

  always_comb begin
    line_ctl.step   = realign_step || in_xfer;
    line_ctl.wr     = in_xfer;
    line_ctl.wr_idx = (ring_wm1_q == '0) ? '0 : COL_W'(1);
    line_ctl.wm1    = ring_wm1_q;
    line_ctl.wdata  = '{up2: above, up: height_i};
  end

  glmr_line u_line (
    .clk_i   (clk_i),
    .ctl_i   (line_ctl),
    .cell0_o (cell0),
    .cell1_o (cell1),
    .cell2_o (cell2)
  );

  // ---------------------------------------------------------------------
  // Decisions
  // ---------------------------------------------------------------------
  logic hit_up, hit_left, hit_end;
  logic [5:0] risk_add;
  logic [1:0] hit_cnt;
  logic [RISK_W:0]  risk_sum;
  logic [COUNT_W:0] cnt_sum;
  logic [RISK_W-1:0]  risk_new;
  logic [COUNT_W-1:0] cnt_new;

  // Cell above the arriving one: its lower neighbor is here now.
  assign hit_up = (rows_q != 2'd0) && (height_i > above)
                  && ((rows_q < 2'd2) || (above2 > above))
                  && ((c_cur == '0) || (left_up2 > above))
                  && (row_end || (right_up > above));

  // Last-row cell to the left: its right neighbor is here now.
  assign hit_left = last_row_i && (c_cur != '0) && (height_i > r0_q)
                    && ((c_cur < COL_W'(2)) || (r1_q > r0_q))
                    && ((rows_q == 2'd0) || (left_up2 > r0_q));

  // Final cell of the last row decides itself.
  assign hit_end = frame_end
                   && ((c_cur == '0) || (r0_q > height_i))
                   && ((rows_q == 2'd0) || (above > height_i));

  assign risk_add = (hit_up   ? ({2'b00, above}    + 6'd1) : 6'd0)
                  + (hit_left ? ({2'b00, r0_q}     + 6'd1) : 6'd0)
                  + (hit_end  ? ({2'b00, height_i} + 6'd1) : 6'd0);
  assign hit_cnt  = {1'b0, hit_up} + {1'b0, hit_left} + {1'b0, hit_end};

  // Saturate once on the combined increment.
  assign risk_sum = {1'b0, risk_q} + (RISK_W + 1)'(risk_add);
  assign cnt_sum  = {1'b0, cnt_q} + (COUNT_W + 1)'(hit_cnt);
  assign risk_new = risk_sum[RISK_W] ? '1 : risk_sum[RISK_W-1:0];
  assign cnt_new  = cnt_sum[COUNT_W] ? '1 : cnt_sum[COUNT_W-1:0];

  // ---------------------------------------------------------------------
  // State update
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RESET;
      ring_wm1_q  <= RING_WM1_RESET;
      ph_q        <= RING_WM1_RESET;
      col_q       <= '0;
      rows_q      <= 2'd0;
      r0_q        <= '0;
      r1_q        <= '0;
      risk_q      <= '0;
      cnt_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        row_width_q <= cfg_row_width_i;
      end
      ring_wm1_q <= ring_wm1_d;
      ph_q       <= ph_d;
      if (in_xfer) begin
        if (frame_end) begin
          // drop all frame state, next cell opens a new frame
          col_q  <= '0;
          rows_q <= 2'd0;
          r0_q   <= '0;
          r1_q   <= '0;
          risk_q <= '0;
          cnt_q  <= '0;
        end else begin
          col_q  <= row_end ? '0 : COL_W'(c_cur + 1'b1);
          if (row_end && (rows_q < 2'd2)) begin
            rows_q <= rows_q + 2'd1;
          end
          r0_q   <= height_i;
          r1_q   <= r0_q;
          risk_q <= risk_new;
          cnt_q  <= cnt_new;
        end
      end
    end
  end

  // Output register: hold a result until taken, refill in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_risk_q <= risk_new;
      out_cnt_q  <= cnt_new;
      out_done_q <= frame_end;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign risk_sum_o     = out_risk_q;
  assign minima_count_o = out_cnt_q;
  assign frame_done_o   = out_done_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  logic frame_cleared;
  assign frame_cleared = (col_q == '0) && (rows_q == 2'd0) && (risk_q == '0) && (cnt_q == '0);

  `GLMR_CHECK_NOW(a_phase_in_ring, ph_q <= ring_wm1_q, "ring phase beyond ring width")
  `GLMR_CHECK_IMPL(a_resize_at_zero, ring_wm1_d != ring_wm1_q, ph_q == '0, "resize off phase zero")
  `GLMR_CHECK_NEXT(a_result_follows, in_xfer, out_valid_q, "transfer without a result")
  `GLMR_CHECK_NEXT(a_frame_clear, in_xfer && frame_end, frame_cleared, "frame state not cleared")

endmodule

[src/glmr_cell.sv]
// One column cell of the rotating line store.
// Depends on glmr_pkg.
module glmr_cell (
  input  logic              clk_i,
  input  glmr_pkg::col_t    idx_i,
  input  glmr_pkg::line_ctl_t ctl_i,
  input  glmr_pkg::cell_t   next_i,
  input  glmr_pkg::cell_t   head_i,
  output glmr_pkg::cell_t   val_o,
  output glmr_pkg::cell_t   fwd_o
);
  import glmr_pkg::*;

  cell_t val_q, val_d;

  // Value handed to the neighbor: the stored one, or the fresh write.
  assign fwd_o = (ctl_i.wr && (idx_i == ctl_i.wr_idx)) ? ctl_i.wdata : val_q;
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.step) begin
      if (idx_i < ctl_i.wm1) begin
        val_d = next_i;
      end else if (idx_i == ctl_i.wm1) begin
        val_d = head_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

[src/glmr_line.sv]
// Chain of column cells forming the two line stores as one ring.
// Depends on glmr_pkg and glmr_cell.
module glmr_line (
  input  logic                clk_i,
  input  glmr_pkg::line_ctl_t ctl_i,
  output glmr_pkg::cell_t     cell0_o,
  output glmr_pkg::cell_t     cell1_o,
  output glmr_pkg::cell_t     cell2_o
);
  import glmr_pkg::*;

  cell_t val[MAX_WIDTH];
  cell_t fwd[MAX_WIDTH];

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
    cell_t next_in;
    if (k == MAX_WIDTH - 1) begin : g_tail
      assign next_in = '0;
    end else begin : g_mid
      assign next_in = fwd[k+1];
    end

    glmr_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (COL_W'(k)),
      .ctl_i  (ctl_i),
      .next_i (next_in),
      .head_i (fwd[0]),
      .val_o  (val[k]),
      .fwd_o  (fwd[k])
    );
  end

  assign cell0_o = val[0];
  assign cell1_o = val[1];
  assign cell2_o = val[2];

endmodule

[test/grid_local_minimum_risk_sum_checker.sv]
// Result checker for the grid local minimum core: predicts the running risk sum,
// minima count and frame-done flag of every cell transfer and compares them in order.
// Depends on glmr_pkg for widths and the row width reset value.
module grid_local_minimum_risk_sum_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [glmr_pkg::ROW_WIDTH_W-1:0] cfg_row_width_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [glmr_pkg::HEIGHT_W-1:0]    height_i,
  input  logic                             last_row_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [glmr_pkg::RISK_W-1:0]      risk_sum_i,
  input  logic [glmr_pkg::COUNT_W-1:0]     minima_count_i,
  input  logic                             frame_done_i,
  output int                               fail_count_o,
  output int                               open_results_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import glmr_pkg::*;

  localparam logic [RISK_W-1:0]  RISK_MAX  = {RISK_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [RISK_W-1:0]  risk;
    logic [COUNT_W-1:0] count;
    logic               done;
  } totals_t;

  totals_t pending_totals[$];

  // Mirror of the block state
  logic [HEIGHT_W-1:0]    upper_row  [MAX_WIDTH];
  logic [HEIGHT_W-1:0]    upper2_row [MAX_WIDTH];
  logic [ROW_WIDTH_W-1:0] row_width;
  int unsigned            column;
  int unsigned            rows_done;
  logic [HEIGHT_W-1:0]    left1;
  logic [HEIGHT_W-1:0]    left2;
  logic [RISK_W-1:0]      risk_acc;
  logic [COUNT_W-1:0]     minima_acc;

  initial begin
    fail_count_o   = 0;
    open_results_o = 0;
  end

  function automatic void add_minimum(logic [HEIGHT_W-1:0] h);
    logic [RISK_W-1:0] inc;
    inc = RISK_W'(h) + RISK_W'(1);
    if (risk_acc > RISK_MAX - inc) risk_acc = RISK_MAX;
    else risk_acc = risk_acc + inc;
    if (minima_acc != COUNT_MAX) minima_acc = minima_acc + COUNT_W'(1);
  endfunction

  // Advance the mirror by one cell and return the totals it reports.
  function automatic totals_t score_cell(logic [HEIGHT_W-1:0] cur, logic last);
    int unsigned         w;
    int unsigned         c;
    logic                row_end;
    logic                ok;
    logic [HEIGHT_W-1:0] cand;
    logic [HEIGHT_W-1:0] above;
    logic [HEIGHT_W-1:0] above2;
    totals_t             res;
    w = row_width;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    c = (column > w - 1) ? w - 1 : column;
    row_end = (c == w - 1);
    above  = upper_row[c];
    above2 = upper2_row[c];

    // the cell above is decided now that its lower neighbor is here
    if (rows_done >= 1) begin
      cand = above;
      ok = cur > cand;
      if (rows_done >= 2 && !(above2 > cand)) ok = 1'b0;
      if (c >= 1 && !(upper2_row[c-1] > cand)) ok = 1'b0;
      if (c + 1 < w && !(upper_row[c+1] > cand)) ok = 1'b0;
      if (ok) add_minimum(cand);
    end
    upper2_row[c] = above;
    upper_row[c]  = cur;

    if (last) begin
      // left neighbor in the last row has its right neighbor now
      if (c >= 1) begin
        cand = left1;
        ok = cur > cand;
        if (c >= 2 && !(left2 > cand)) ok = 1'b0;
        if (rows_done >= 1 && !(upper2_row[c-1] > cand)) ok = 1'b0;
        if (ok) add_minimum(cand);
      end
      // final cell of the row has no right or lower neighbor
      if (row_end) begin
        ok = 1'b1;
        if (c >= 1 && !(left1 > cur)) ok = 1'b0;
        if (rows_done >= 1 && !(upper2_row[c] > cur)) ok = 1'b0;
        if (ok) add_minimum(cur);
      end
    end
    left2 = left1;
    left1 = cur;

    res.risk  = risk_acc;
    res.count = minima_acc;
    res.done  = last && row_end;

    if (res.done) begin
      risk_acc   = '0;
      minima_acc = '0;
      column     = 0;
      rows_done  = 0;
      left1      = '0;
      left2      = '0;
    end else if (row_end) begin
      column = 0;
      if (rows_done < 2) rows_done++;
    end else begin
      column = c + 1;
    end
    return res;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", field, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    totals_t want;
    totals_t fresh;
    if (!rst_ni) begin
      pending_totals.delete();
      row_width  = ROW_WIDTH_RESET;
      column     = 0;
      rows_done  = 0;
      left1      = '0;
      left2      = '0;
      risk_acc   = '0;
      minima_acc = '0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_row[i]  = '0;
        upper2_row[i] = '0;
      end
    end else begin
      // results first: any result at this edge belongs to an earlier cell
      if (out_valid_i && out_ready_i) begin
        if (pending_totals.size() == 0) begin
          $error("result transfer with no cell waiting for it");
          fail_count_o++;
        end else begin
          want = pending_totals.pop_front();
          check_field("risk_sum", 32'(want.risk), 32'(risk_sum_i));
          check_field("minima_count", 32'(want.count), 32'(minima_count_i));
          check_field("frame_done", 32'(want.done), 32'(frame_done_i));
        end
      end
      // a cell taken at this edge still sees the width held before it
      if (in_valid_i && in_ready_i) begin
        fresh = score_cell(height_i, last_row_i);
        pending_totals.insert(pending_totals.size(), fresh);
      end
      if (cfg_valid_i && cfg_ready_i) row_width = cfg_row_width_i;
    end
    open_results_o = pending_totals.size();
  end

endmodule

[test/grid_local_minimum_risk_sum_core_test.sv]
// Top of the grid local minimum testbench: clock, reset, cell and width stimulus,
// receiver stalls, watchdog and verdict. Depends on glmr_pkg, the core and
// grid_local_minimum_risk_sum_checker, which does all the predicting and comparing.
module grid_local_minimum_risk_sum_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import glmr_pkg::*;

  localparam int CELL_TARGET     = 1800;  // cells to send before wrapping up
  localparam int IDLE_LIMIT      = 4000;  // cycles with no transfer at all before giving up
  localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall, well past the core's buffering
  localparam int DRAIN_CYCLES    = 20;

  // How the receiver drives out_ready in between long hold-offs
  typedef enum int unsigned {
    STALL_NONE,
    STALL_COIN,
    STALL_EVERY_FOURTH,
    STALL_RARE
  } stall_mode_e;

  // Shape of the height values inside one frame
  typedef enum int unsigned {
    HEIGHTS_DIGITS,    // 0..9, as in the intended use
    HEIGHTS_FLAT,      // 0..2, many equal neighbors
    HEIGHTS_FULL,      // 0..15, heights above nine included
    HEIGHTS_PLATEAU    // flat base with scattered dips
  } height_mode_e;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid     = 1'b0;
  logic                   cfg_ready;
  logic [ROW_WIDTH_W-1:0] cfg_row_width = '0;
  logic                   in_valid      = 1'b0;
  logic                   in_ready;
  logic [HEIGHT_W-1:0]    height        = '0;
  logic                   last_row      = 1'b0;
  logic                   out_valid;
  logic                   out_ready     = 1'b0;
  logic [RISK_W-1:0]      risk_sum;
  logic [COUNT_W-1:0]     minima_count;
  logic                   frame_done;

  int fail_count;
  int open_results;
  int cells_sent   = 0;
  int results_seen = 0;
  int idle_cycles  = 0;
  int burst_left   = 0;

  // Column tracking on the sender side, so rows can be flagged where they really end
  int unsigned width_now;
  int unsigned col_now;

  grid_local_minimum_risk_sum_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_row_width_i (cfg_row_width),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .height_i        (height),
    .last_row_i      (last_row),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .risk_sum_o      (risk_sum),
    .minima_count_o  (minima_count),
    .frame_done_o    (frame_done)
  );

  grid_local_minimum_risk_sum_checker minima_watch (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_row_width_i (cfg_row_width),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .height_i        (height),
    .last_row_i      (last_row),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .risk_sum_i      (risk_sum),
    .minima_count_i  (minima_count),
    .frame_done_i    (frame_done),
    .fail_count_o    (fail_count),
    .open_results_o  (open_results)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog: count edges with no transfer on any channel. A width change can
  // stall the input while the ring realigns, and the receiver hold-off adds
  // its own stretch, so the limit sits far above both.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) results_seen++;
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Receiver: switch at random between stall patterns, and at a
  // few points hold off completely so the core fills and stalls its input.
  initial begin : receiver
    stall_mode_e mode;
    int unsigned mode_left;
    int unsigned phase;
    int          hold_at;
    mode      = STALL_NONE;
    mode_left = 0;
    phase     = 0;
    hold_at   = 300;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (results_seen >= hold_at) begin
        hold_at += 700;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        phase++;
        case (mode)
          STALL_NONE:         out_ready <= 1'b1;
          STALL_COIN:         out_ready <= 1'($urandom_range(0, 1));
          STALL_EVERY_FOURTH: out_ready <= (phase % 4 == 0);
          default:            out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  function automatic int unsigned effective_width(logic [ROW_WIDTH_W-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_WIDTH) return MAX_WIDTH;
    return w;
  endfunction

  function automatic logic [ROW_WIDTH_W-1:0] pick_width();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return ROW_WIDTH_W'(1);
    if (r == 2) return ROW_WIDTH_W'($urandom_range(MAX_WIDTH, 511));
    if (r == 3) return ROW_WIDTH_W'($urandom_range(13, 80));
    return ROW_WIDTH_W'($urandom_range(2, 12));
  endfunction

  function automatic logic [HEIGHT_W-1:0] pick_height(height_mode_e mode, int unsigned base);
    case (mode)
      HEIGHTS_DIGITS: return HEIGHT_W'($urandom_range(0, 9));
      HEIGHTS_FLAT:   return HEIGHT_W'($urandom_range(0, 2));
      HEIGHTS_FULL:   return HEIGHT_W'($urandom_range(0, 15));
      default:        return ($urandom_range(0, 5) == 0) ?
                             HEIGHT_W'(base - $urandom_range(1, 3)) : HEIGHT_W'(base);
    endcase
  endfunction

  // Offer one cell and hold it until the core takes it. Called and left at a
  // falling edge. Between bursts drop valid for a random gap.
  task automatic send_cell(input logic [HEIGHT_W-1:0] h, input logic lr,
                           output logic row_end);
    int unsigned c;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 30);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid <= 1'b1;
    height   <= h;
    last_row <= lr;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    cells_sent++;
    // a column past the current width counts as the last one of its row
    c = (col_now > width_now - 1) ? width_now - 1 : col_now;
    row_end = (c == width_now - 1);
    col_now = row_end ? 0 : c + 1;
  endtask

  // Stop offering cells and wait until every result is back. Always advance
  // at least one falling edge so valid is never dropped and raised in one step.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (open_results != 0);
  endtask

  task automatic set_row_width(input logic [ROW_WIDTH_W-1:0] w);
    settle();
    cfg_valid     <= 1'b1;
    cfg_row_width <= w;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    width_now = effective_width(w);
  endtask

  // Send a short run of cells given as hex digits, most significant first;
  // cells from index flagged_from on carry the last-row flag.
  task automatic send_run(input logic [63:0] digits, input int unsigned count,
                          input int unsigned flagged_from);
    logic row_end;
    for (int unsigned i = 0; i < count; i++)
      send_cell(digits[4*(count-1-i) +: 4], i >= flagged_from, row_end);
  endtask

  // One frame of the given number of rows. A noisy frame sets the last-row
  // flag at random in the upper rows; a reshaped frame changes the width at a
  // random cell in the middle of the frame.
  task automatic send_frame(input int unsigned rows, input height_mode_e mode,
                            input logic noisy, input logic reshape);
    int unsigned row;
    int unsigned base;
    int unsigned change_at;
    int unsigned n;
    logic        row_end;
    logic        flag;
    row  = 0;
    n    = 0;
    base = $urandom_range(3, 9);
    change_at = (reshape && rows * width_now > 1) ? $urandom_range(1, rows * width_now - 1) : 0;
    while (row < rows) begin
      if (change_at != 0 && n == change_at) set_row_width(ROW_WIDTH_W'($urandom_range(0, 20)));
      flag = (row == rows - 1) || (noisy && $urandom_range(0, 3) == 0);
      send_cell(pick_height(mode, base), flag, row_end);
      n++;
      if (row_end) row++;
    end
  endtask

  initial begin : stimulus
    width_now = effective_width(ROW_WIDTH_RESET);
    col_now   = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // 3x3 map with minima in all four corners and the center, then a last row
    // whose two lowest cells tie
    set_row_width(ROW_WIDTH_W'(3));
    send_run(64'h1_5_0_5_2_5_0_5_3, 9, 6);
    send_run(64'h2_2_7, 3, 0);

    // zero width acts as a single column; heights above nine
    set_row_width('0);
    send_run(64'hF_A_C, 3, 2);

    // shrink the width mid-row: the fourth cell lands past the new width and
    // closes the row
    set_row_width(ROW_WIDTH_W'(4));
    send_run(64'h8_3_6, 3, 3);
    set_row_width(ROW_WIDTH_W'(2));
    send_run(64'h9_1_0, 3, 1);

    // Full-width frame of two rows: every line store entry gets written, so
    // later mid-frame width growth never reads an unwritten column.
    set_row_width(ROW_WIDTH_W'(MAX_WIDTH));
    set_row_width('1);
    send_frame(2, HEIGHTS_DIGITS, 1'b0, 1'b0);

    // Random frames: mostly clean frames, some with stray flags and some with
    // a width change in the middle. Wide rows get a single row to keep it short.
    while (cells_sent < CELL_TARGET) begin
      set_row_width(pick_width());
      repeat ($urandom_range(1, 2)) begin
        send_frame((width_now >= 64) ? 1 : $urandom_range(1, 6),
                   height_mode_e'($urandom_range(0, 3)),
                   $urandom_range(0, 7) == 0,
                   $urandom_range(0, 5) == 0);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && open_results == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
